FILE: rtl/tahp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tahp_pkg: shared types and constants of the two-axis home and position core
// Holds the phase and status encodings, drive codes, register indexes and
// the structs that carry items, results and configuration between modules.
// ----------------------------------------------------------------------------
package tahp_pkg;

  // Highest slot number that a move accepts.
  localparam int unsigned MAX_SLOT = 15;
  localparam logic [7:0] SLOT_LIMIT = 8'(MAX_SLOT);

  // Reset values of the timing registers.
  localparam logic [15:0] BACKOFF_RESET = 16'd500;
  localparam logic [15:0] TIMEOUT_RESET = 16'd20000;

  // Largest position a move target may reach.
  localparam logic [16:0] TARGET_MAX = 17'd32767;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_BACKOFF = 2'd1,
    PH_SEEK    = 2'd2,
    PH_MOVE    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_HOME = 2'd1,
    KIND_MOVE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_NONE        = 3'd0,
    ST_HOME_OK     = 3'd1,
    ST_HOME_MISSED = 3'd2,
    ST_BLOCKED     = 3'd3,
    ST_MOVE_DONE   = 3'd4
  } status_e;

  // Motor drive codes.
  localparam logic [1:0] DRV_BRAKE = 2'd0;
  localparam logic [1:0] DRV_LEFT  = 2'd1;
  localparam logic [1:0] DRV_RIGHT = 2'd2;
  localparam logic [1:0] DRV_DOWN  = 2'd1;
  localparam logic [1:0] DRV_UP    = 2'd2;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_COLUMN_ORIGIN = 3'd0;
  localparam logic [2:0] REG_COLUMN_PITCH  = 3'd1;
  localparam logic [2:0] REG_ROW_ORIGIN    = 3'd2;
  localparam logic [2:0] REG_ROW_PITCH     = 3'd3;
  localparam logic [2:0] REG_LIFT_HEIGHT   = 3'd4;
  localparam logic [2:0] REG_BACKOFF       = 3'd5;
  localparam logic [2:0] REG_HOME_TIMEOUT  = 3'd6;

  typedef struct packed {
    logic [13:0] column_origin;
    logic [13:0] column_pitch;
    logic [13:0] row_origin;
    logic [11:0] row_pitch;
    logic [11:0] lift_height;
    logic [15:0] backoff_ticks;
    logic [15:0] home_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic       lift;
    logic       lower_switch;
    logic       left_switch;
    logic       horiz_pulse;
    logic       vert_pulse;
  } item_t;

  typedef struct packed {
    logic [1:0]         horiz_drive;
    logic [1:0]         vert_drive;
    logic               busy_res;
    status_e            status;
    logic signed [15:0] x_position;
    logic signed [15:0] y_position;
  } result_t;

  typedef struct packed {
    logic        running;
    logic [15:0] count;
    logic [15:0] position;
  } axis_t;

endpackage

FILE: rtl/tahp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tahp_cfg: configuration register file
// APB-style slave holding the shelf geometry and the homing time limits.
// ----------------------------------------------------------------------------
module tahp_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tahp_pkg::cfg_t    cfg_o
);
  import tahp_pkg::*;

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_COLUMN_ORIGIN: cfg_d.column_origin      = pwdata[13:0];
        REG_COLUMN_PITCH:  cfg_d.column_pitch       = pwdata[13:0];
        REG_ROW_ORIGIN:    cfg_d.row_origin         = pwdata[13:0];
        REG_ROW_PITCH:     cfg_d.row_pitch          = pwdata[11:0];
        REG_LIFT_HEIGHT:   cfg_d.lift_height        = pwdata[11:0];
        REG_BACKOFF:       cfg_d.backoff_ticks      = pwdata[15:0];
        REG_HOME_TIMEOUT:  cfg_d.home_timeout_ticks = pwdata[15:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COLUMN_ORIGIN: prdata = {18'd0, cfg_q.column_origin};
      REG_COLUMN_PITCH:  prdata = {18'd0, cfg_q.column_pitch};
      REG_ROW_ORIGIN:    prdata = {18'd0, cfg_q.row_origin};
      REG_ROW_PITCH:     prdata = {20'd0, cfg_q.row_pitch};
      REG_LIFT_HEIGHT:   prdata = {20'd0, cfg_q.lift_height};
      REG_BACKOFF:       prdata = {16'd0, cfg_q.backoff_ticks};
      REG_HOME_TIMEOUT:  prdata = {16'd0, cfg_q.home_timeout_ticks};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.column_origin      <= 14'd0;
      cfg_q.column_pitch       <= 14'd0;
      cfg_q.row_origin         <= 14'd0;
      cfg_q.row_pitch          <= 12'd0;
      cfg_q.lift_height        <= 12'd0;
      cfg_q.backoff_ticks      <= BACKOFF_RESET;
      cfg_q.home_timeout_ticks <= TIMEOUT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/tahp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tahp_step: sequencer state and single-tick update
// Holds the homing and move state and computes the result of one tick.
// ----------------------------------------------------------------------------
module tahp_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  tahp_pkg::item_t   item_i,
  input  tahp_pkg::cfg_t    cfg_i,
  output tahp_pkg::result_t result_o
);
  import tahp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] hpos_q, hpos_d, vpos_q, vpos_d;
  logic        hrun_q, hrun_d, vrun_q, vrun_d;
  logic [15:0] timer_q, timer_d;
  logic [15:0] hcnt_q, hcnt_d, vcnt_q, vcnt_d;
  logic [15:0] hmag_q, hmag_d, vmag_q, vmag_d;
  logic        hfwd_q, hfwd_d, vfwd_q, vfwd_d;

  logic [15:0] timer_inc;
  logic [3:0]  slot_m1;
  logic [14:0] row_off;
  logic [16:0] tx_raw, ty_raw, tx_sat, ty_sat;
  logic signed [16:0] hdist, vdist;
  logic [15:0] hmag_new, vmag_new;
  axis_t       h_axis, v_axis;
  logic [1:0]  hd, vd;
  status_e     status;
  logic        move_ok;

  // One axis of a move: count a pulse, stop and commit the position once
  // the count reaches the distance.
  function automatic axis_t axis_step(logic run, logic [15:0] cnt, logic [15:0] mag,
                                      logic fwd, logic [15:0] pos, logic pulse);
    axis_t a;
    a.running  = run;
    a.count    = cnt;
    a.position = pos;
    if (run) begin
      if (pulse && cnt != COUNT_MAX) begin
        a.count = cnt + 16'd1;
      end
      if (a.count >= mag) begin
        a.running  = 1'b0;
        a.position = fwd ? pos + a.count : pos - a.count;
      end
    end
    return a;
  endfunction

  assign timer_inc = (timer_q != COUNT_MAX) ? timer_q + 16'd1 : timer_q;
  assign move_ok   = {4'd0, item_i.slot} <= SLOT_LIMIT;

  // Move target from the slot: two columns alternate, rows climb by pairs.
  always_comb begin
    slot_m1 = item_i.slot - 4'd1;
    row_off = {12'd0, slot_m1[3:1]} * {3'd0, cfg_i.row_pitch};
    if (item_i.slot != 4'd0) begin
      tx_raw = {3'd0, cfg_i.column_origin} +
               (slot_m1[0] ? {3'd0, cfg_i.column_pitch} : 17'd0);
      ty_raw = {3'd0, cfg_i.row_origin} + {2'd0, row_off};
    end else begin
      tx_raw = 17'd0;
      ty_raw = 17'd0;
    end
    if (item_i.lift) begin
      ty_raw = ty_raw + {5'd0, cfg_i.lift_height};
    end
    tx_sat   = (tx_raw > TARGET_MAX) ? TARGET_MAX : tx_raw;
    ty_sat   = (ty_raw > TARGET_MAX) ? TARGET_MAX : ty_raw;
    hdist    = $signed(tx_sat) - $signed({hpos_q[15], hpos_q});
    vdist    = $signed(ty_sat) - $signed({vpos_q[15], vpos_q});
    hmag_new = hdist[16] ? 16'(-hdist) : hdist[15:0];
    vmag_new = vdist[16] ? 16'(-vdist) : vdist[15:0];
  end

  assign h_axis = axis_step(hrun_q, hcnt_q, hmag_q, hfwd_q, hpos_q, item_i.horiz_pulse);
  assign v_axis = axis_step(vrun_q, vcnt_q, vmag_q, vfwd_q, vpos_q, item_i.vert_pulse);

  always_comb begin
    phase_d = phase_q;
    hpos_d  = hpos_q;
    vpos_d  = vpos_q;
    hrun_d  = hrun_q;
    vrun_d  = vrun_q;
    timer_d = timer_q;
    hcnt_d  = hcnt_q;
    vcnt_d  = vcnt_q;
    hmag_d  = hmag_q;
    vmag_d  = vmag_q;
    hfwd_d  = hfwd_q;
    vfwd_d  = vfwd_q;
    hd      = DRV_BRAKE;
    vd      = DRV_BRAKE;
    status  = ST_NONE;
    case (phase_q)
      PH_IDLE: begin
        if (item_i.kind == KIND_HOME) begin
          timer_d = 16'd0;
          if (item_i.lower_switch || item_i.left_switch) begin
            phase_d = PH_BACKOFF;
            hrun_d  = item_i.left_switch;
            vrun_d  = item_i.lower_switch;
            hd      = item_i.left_switch ? DRV_RIGHT : DRV_BRAKE;
            vd      = item_i.lower_switch ? DRV_UP : DRV_BRAKE;
          end else begin
            phase_d = PH_SEEK;
            hrun_d  = 1'b1;
            vrun_d  = 1'b1;
            hd      = DRV_LEFT;
            vd      = DRV_DOWN;
          end
        end else if (item_i.kind == KIND_MOVE && move_ok) begin
          hcnt_d = 16'd0;
          vcnt_d = 16'd0;
          hmag_d = hmag_new;
          vmag_d = vmag_new;
          hfwd_d = !hdist[16] && (hdist != 17'sd0);
          vfwd_d = !vdist[16] && (vdist != 17'sd0);
          hrun_d = hdist != 17'sd0;
          vrun_d = vdist != 17'sd0;
          if (hrun_d || vrun_d) begin
            phase_d = PH_MOVE;
            hd      = hrun_d ? (hfwd_d ? DRV_RIGHT : DRV_LEFT) : DRV_BRAKE;
            vd      = vrun_d ? (vfwd_d ? DRV_UP : DRV_DOWN) : DRV_BRAKE;
          end else begin
            status = ST_MOVE_DONE;
          end
        end
      end
      PH_BACKOFF: begin
        timer_d = timer_inc;
        if (timer_inc >= cfg_i.backoff_ticks) begin
          if (item_i.lower_switch || item_i.left_switch) begin
            phase_d = PH_IDLE;
            hrun_d  = 1'b0;
            vrun_d  = 1'b0;
            status  = ST_BLOCKED;
          end else begin
            phase_d = PH_SEEK;
            hrun_d  = 1'b1;
            vrun_d  = 1'b1;
            timer_d = 16'd0;
            hd      = DRV_LEFT;
            vd      = DRV_DOWN;
          end
        end else begin
          hd = hrun_q ? DRV_RIGHT : DRV_BRAKE;
          vd = vrun_q ? DRV_UP : DRV_BRAKE;
        end
      end
      PH_SEEK: begin
        hrun_d  = hrun_q && !item_i.left_switch;
        vrun_d  = vrun_q && !item_i.lower_switch;
        timer_d = timer_inc;
        if ((!hrun_d && !vrun_d) || timer_inc >= cfg_i.home_timeout_ticks) begin
          phase_d = PH_IDLE;
          hrun_d  = 1'b0;
          vrun_d  = 1'b0;
          hpos_d  = 16'd0;
          vpos_d  = 16'd0;
          status  = (item_i.lower_switch && item_i.left_switch) ? ST_HOME_OK
                                                                : ST_HOME_MISSED;
        end else begin
          hd = hrun_d ? DRV_LEFT : DRV_BRAKE;
          vd = vrun_d ? DRV_DOWN : DRV_BRAKE;
        end
      end
      PH_MOVE: begin
        hrun_d = h_axis.running;
        hcnt_d = h_axis.count;
        hpos_d = h_axis.position;
        vrun_d = v_axis.running;
        vcnt_d = v_axis.count;
        vpos_d = v_axis.position;
        if (!h_axis.running && !v_axis.running) begin
          phase_d = PH_IDLE;
          status  = ST_MOVE_DONE;
        end else begin
          hd = h_axis.running ? (hfwd_q ? DRV_RIGHT : DRV_LEFT) : DRV_BRAKE;
          vd = v_axis.running ? (vfwd_q ? DRV_UP : DRV_DOWN) : DRV_BRAKE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  assign result_o.horiz_drive = hd;
  assign result_o.vert_drive  = vd;
  assign result_o.busy_res    = phase_d != PH_IDLE;
  assign result_o.status      = status;
  assign result_o.x_position  = $signed(hpos_d);
  assign result_o.y_position  = $signed(vpos_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hpos_q  <= 16'd0;
      vpos_q  <= 16'd0;
      hrun_q  <= 1'b0;
      vrun_q  <= 1'b0;
      timer_q <= 16'd0;
      hcnt_q  <= 16'd0;
      vcnt_q  <= 16'd0;
      hmag_q  <= 16'd0;
      vmag_q  <= 16'd0;
      hfwd_q  <= 1'b0;
      vfwd_q  <= 1'b0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      hpos_q  <= hpos_d;
      vpos_q  <= vpos_d;
      hrun_q  <= hrun_d;
      vrun_q  <= vrun_d;
      timer_q <= timer_d;
      hcnt_q  <= hcnt_d;
      vcnt_q  <= vcnt_d;
      hmag_q  <= hmag_d;
      vmag_q  <= vmag_d;
      hfwd_q  <= hfwd_d;
      vfwd_q  <= vfwd_d;
    end
  end

endmodule

FILE: rtl/two_axis_home_and_position_core.sv
`timescale 1ns / 1ps
// Timing: a tick held in the input register is processed at an edge at which
// the result register is free, and its result is then offered from that register.
// Throughput: one tick per clock cycle, held up only by a stalled result.
// Reset: registers return to their defaults (backoff 500, timeout 20000,
// geometry zero), the sequencer goes idle and both positions become zero.
// ----------------------------------------------------------------------------
// two_axis_home_and_position_core: two-axis gantry homing and positioning
// Takes one sampling tick per transfer (endstops, encoder edges, command),
// runs the homing or move sequencer and returns motor drives, status and
// positions for every tick.
// ----------------------------------------------------------------------------
module two_axis_home_and_position_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Tick input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [3:0]         slot_i,
  input  logic               lift_i,
  input  logic               lower_switch_i,
  input  logic               left_switch_i,
  input  logic               horiz_pulse_i,
  input  logic               vert_pulse_i,
  // Result output channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         horiz_drive_o,
  output logic [1:0]         vert_drive_o,
  output logic               busy_res_o,
  output logic [2:0]         status_o,
  output logic signed [15:0] x_position_o,
  output logic signed [15:0] y_position_o
);
  import tahp_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  logic    out_valid_q;
  result_t result_d;
  result_t result_q;
  logic    in_accept;
  logic    advance;

  tahp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The sequencer state moves forward only when a held tick can place its
  // result in the result register, either because that register is empty or
  // because its result transfers in this same cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  tahp_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .result_o  (result_d)
  );

  // Input register: the held tick can be replaced in the same cycle it is used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.kind         <= kind_i;
      item_q.slot         <= slot_i;
      item_q.lift         <= lift_i;
      item_q.lower_switch <= lower_switch_i;
      item_q.left_switch  <= left_switch_i;
      item_q.horiz_pulse  <= horiz_pulse_i;
      item_q.vert_pulse   <= vert_pulse_i;
    end
  end

  // Result register: holds a result until its transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign horiz_drive_o = result_q.horiz_drive;
  assign vert_drive_o  = result_q.vert_drive;
  assign busy_res_o    = result_q.busy_res;
  assign status_o      = result_q.status;
  assign x_position_o  = result_q.x_position;
  assign y_position_o  = result_q.y_position;

  // A sequence reports its status only on the tick it ends.
  a_status_when_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_NONE |-> !busy_res_o)
    else $error("status reported while a sequence is still running");

  // Motors are braked whenever no sequence is running.
  a_brake_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> horiz_drive_o == DRV_BRAKE && vert_drive_o == DRV_BRAKE)
    else $error("motor driven while idle");

  // The end of homing always leaves both positions at zero.
  a_home_zeroes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_HOME_OK || status_o == ST_HOME_MISSED)
    |-> x_position_o == 16'sd0 && y_position_o == 16'sd0)
    else $error("homing ended with a nonzero position");

  // The input side is held up only by a full, stalled result register.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

endmodule

FILE: sim/tb_two_axis_home_and_position_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_axis_home_and_position_core: self-checking bench for the gantry core
// Sends sampling ticks (endstops, encoder edges, home and move commands)
// through the valid/stall input channel. A cycle-free model of the homing and
// move sequencer predicts the drives, status and positions for each accepted
// tick, and every returned result is compared field by field against it.
// ----------------------------------------------------------------------------

module tb_two_axis_home_and_position_core;
  import tahp_pkg::*;

  // Tracks the gantry sequencer one tick at a time and holds the results that
  // the core still owes, oldest first.
  class gantry_tracker;
    cfg_t               cfg;
    phase_e             phase;
    logic [15:0]        x_pos;
    logic [15:0]        y_pos;
    bit                 x_run;
    bit                 y_run;
    int unsigned        tick_count;
    int unsigned        x_pulses;
    int unsigned        y_pulses;
    int                 x_dist;
    int                 y_dist;
    result_t            expected_drives[$];
    int                 mismatches;
    int                 results_checked;

    function new();
      cfg = '0;
      cfg.backoff_ticks = BACKOFF_RESET;
      cfg.home_timeout_ticks = TIMEOUT_RESET;
      phase = PH_IDLE;
      x_pos = '0;
      y_pos = '0;
      x_run = 0;
      y_run = 0;
      tick_count = 0;
      x_pulses = 0;
      y_pulses = 0;
      x_dist = 0;
      y_dist = 0;
      mismatches = 0;
      results_checked = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_COLUMN_ORIGIN: cfg.column_origin = value[13:0];
        REG_COLUMN_PITCH:  cfg.column_pitch = value[13:0];
        REG_ROW_ORIGIN:    cfg.row_origin = value[13:0];
        REG_ROW_PITCH:     cfg.row_pitch = value[11:0];
        REG_LIFT_HEIGHT:   cfg.lift_height = value[11:0];
        REG_BACKOFF:       cfg.backoff_ticks = value[15:0];
        REG_HOME_TIMEOUT:  cfg.home_timeout_ticks = value[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction

    // Right and up share one code, as do left and down.
    function logic [1:0] drive_code(bit running, int delta);
      if (!running) return DRV_BRAKE;
      return (delta > 0) ? DRV_RIGHT : DRV_LEFT;
    endfunction

    // Counts one encoder edge on a running axis and settles its position once
    // the count covers the distance. Returns whether the axis keeps running.
    function bit advance_axis(input bit running, inout int unsigned pulses,
                              input int delta, inout logic [15:0] pos,
                              input bit pulse);
      int unsigned span;
      if (!running) return 0;
      if (pulse && pulses < COUNT_MAX) pulses++;
      span = (delta < 0) ? -delta : delta;
      if (pulses < span) return 1;
      if (delta > 0) pos = pos + 16'(pulses);
      else pos = pos - 16'(pulses);
      return 0;
    endfunction

    function void enter_seek();
      phase = PH_SEEK;
      x_run = 1;
      y_run = 1;
      tick_count = 0;
    endfunction

    function void predict_tick(item_t it);
      result_t     r;
      logic [1:0]  hd;
      logic [1:0]  vd;
      status_e     st;
      int          tx;
      int          ty;
      int unsigned s;
      hd = DRV_BRAKE;
      vd = DRV_BRAKE;
      st = ST_NONE;
      case (phase)
        PH_IDLE: begin
          if (it.kind == KIND_HOME) begin
            if (it.lower_switch || it.left_switch) begin
              phase = PH_BACKOFF;
              x_run = it.left_switch;
              y_run = it.lower_switch;
              tick_count = 0;
              hd = it.left_switch ? DRV_RIGHT : DRV_BRAKE;
              vd = it.lower_switch ? DRV_UP : DRV_BRAKE;
            end else begin
              enter_seek();
              hd = DRV_LEFT;
              vd = DRV_DOWN;
            end
          end else if (it.kind == KIND_MOVE && it.slot <= MAX_SLOT) begin
            tx = 0;
            ty = 0;
            if (it.slot != 0) begin
              s = it.slot - 1;
              tx = cfg.column_origin + (s % 2) * cfg.column_pitch;
              ty = cfg.row_origin + (s / 2) * cfg.row_pitch;
            end
            if (it.lift) ty += cfg.lift_height;
            if (tx > int'(TARGET_MAX)) tx = int'(TARGET_MAX);
            if (ty > int'(TARGET_MAX)) ty = int'(TARGET_MAX);
            x_dist = tx - int'($signed(x_pos));
            y_dist = ty - int'($signed(y_pos));
            x_pulses = 0;
            y_pulses = 0;
            x_run = (x_dist != 0);
            y_run = (y_dist != 0);
            if (x_run || y_run) begin
              phase = PH_MOVE;
              hd = drive_code(x_run, x_dist);
              vd = drive_code(y_run, y_dist);
            end else begin
              st = ST_MOVE_DONE;
            end
          end
        end
        PH_BACKOFF: begin
          if (tick_count < 65535) tick_count++;
          if (tick_count >= cfg.backoff_ticks) begin
            x_run = 0;
            y_run = 0;
            if (it.lower_switch || it.left_switch) begin
              phase = PH_IDLE;
              st = ST_BLOCKED;
            end else begin
              enter_seek();
              hd = DRV_LEFT;
              vd = DRV_DOWN;
            end
          end else begin
            hd = x_run ? DRV_RIGHT : DRV_BRAKE;
            vd = y_run ? DRV_UP : DRV_BRAKE;
          end
        end
        PH_SEEK: begin
          if (y_run && it.lower_switch) y_run = 0;
          if (x_run && it.left_switch) x_run = 0;
          if (tick_count < 65535) tick_count++;
          if ((!x_run && !y_run) || tick_count >= cfg.home_timeout_ticks) begin
            x_run = 0;
            y_run = 0;
            x_pos = '0;
            y_pos = '0;
            phase = PH_IDLE;
            st = (it.lower_switch && it.left_switch) ? ST_HOME_OK : ST_HOME_MISSED;
          end else begin
            hd = x_run ? DRV_LEFT : DRV_BRAKE;
            vd = y_run ? DRV_DOWN : DRV_BRAKE;
          end
        end
        default: begin
          x_run = advance_axis(x_run, x_pulses, x_dist, x_pos, it.horiz_pulse);
          y_run = advance_axis(y_run, y_pulses, y_dist, y_pos, it.vert_pulse);
          if (!x_run && !y_run) begin
            phase = PH_IDLE;
            st = ST_MOVE_DONE;
          end else begin
            hd = drive_code(x_run, x_dist);
            vd = drive_code(y_run, y_dist);
          end
        end
      endcase
      r.horiz_drive = hd;
      r.vert_drive = vd;
      r.busy_res = (phase != PH_IDLE);
      r.status = st;
      r.x_position = x_pos;
      r.y_position = y_pos;
      expected_drives.push_back(r);
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("[%0t] MISMATCH on result %0d: %s", $time, results_checked, what);
    endtask

    task check_result(result_t got);
      result_t want;
      results_checked++;
      if (expected_drives.size() == 0) begin
        flag_mismatch("result arrived with no tick waiting for it");
        return;
      end
      want = expected_drives.pop_front();
      if (got.horiz_drive !== want.horiz_drive)
        flag_mismatch($sformatf("horiz_drive %0d, expected %0d",
                                got.horiz_drive, want.horiz_drive));
      if (got.vert_drive !== want.vert_drive)
        flag_mismatch($sformatf("vert_drive %0d, expected %0d",
                                got.vert_drive, want.vert_drive));
      if (got.busy_res !== want.busy_res)
        flag_mismatch($sformatf("busy_res %0d, expected %0d",
                                got.busy_res, want.busy_res));
      if (got.status !== want.status)
        flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.x_position !== want.x_position)
        flag_mismatch($sformatf("x_position %0d, expected %0d",
                                got.x_position, want.x_position));
      if (got.y_position !== want.y_position)
        flag_mismatch($sformatf("y_position %0d, expected %0d",
                                got.y_position, want.y_position));
    endtask
  endclass

  // Kind code 3 has no meaning and must behave as a plain tick.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Cycles without any transfer on either channel before the run is abandoned.
  localparam int QUIET_LIMIT = 2000;
  // Random ticks per segment of the random part.
  localparam int SEG_TICKS = 170;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         kind_i = '0;
  logic [3:0]         slot_i = '0;
  logic               lift_i = 1'b0;
  logic               lower_switch_i = 1'b0;
  logic               left_switch_i = 1'b0;
  logic               horiz_pulse_i = 1'b0;
  logic               vert_pulse_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         horiz_drive_o;
  logic [1:0]         vert_drive_o;
  logic               busy_res_o;
  logic [2:0]         status_o;
  logic signed [15:0] x_position_o;
  logic signed [15:0] y_position_o;

  gantry_tracker tracker;

  // Percent chance per cycle that the sender holds back a tick and that the
  // receiver stalls a result.
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  two_axis_home_and_position_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .slot_i         (slot_i),
    .lift_i         (lift_i),
    .lower_switch_i (lower_switch_i),
    .left_switch_i  (left_switch_i),
    .horiz_pulse_i  (horiz_pulse_i),
    .vert_pulse_i   (vert_pulse_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .horiz_drive_o  (horiz_drive_o),
    .vert_drive_o   (vert_drive_o),
    .busy_res_o     (busy_res_o),
    .status_o       (status_o),
    .x_position_o   (x_position_o),
    .y_position_o   (y_position_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // The receiver stalls at random, independent of what is on the bus.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Every result transfer is checked against the oldest prediction. Signals
  // are read right after the edge, so they still hold the values that
  // decided the transfer.
  always @(posedge clk_i) begin : result_monitor
    result_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.horiz_drive = horiz_drive_o;
      seen.vert_drive = vert_drive_o;
      seen.busy_res = busy_res_o;
      seen.status = status_e'(status_o);
      seen.x_position = x_position_o;
      seen.y_position = y_position_o;
      tracker.check_result(seen);
    end
  end

  // Watchdog: a long stretch with no transfer at all means the core hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One register write: a setup cycle, an access cycle, then a cycle with the
  // bus idle so that back-to-back writes never toggle psel within one step.
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_register(idx, value);
    @(posedge clk_i);
  endtask

  task automatic apply_config(input cfg_t c);
    write_register(REG_COLUMN_ORIGIN, 32'(c.column_origin));
    write_register(REG_COLUMN_PITCH, 32'(c.column_pitch));
    write_register(REG_ROW_ORIGIN, 32'(c.row_origin));
    write_register(REG_ROW_PITCH, 32'(c.row_pitch));
    write_register(REG_LIFT_HEIGHT, 32'(c.lift_height));
    write_register(REG_BACKOFF, 32'(c.backoff_ticks));
    write_register(REG_HOME_TIMEOUT, 32'(c.home_timeout_ticks));
  endtask

  // Offers one tick, with a random number of idle cycles first, and holds it
  // until the core takes it. The tracker predicts its result on acceptance.
  task automatic send_tick(input logic [1:0] kind, input logic [3:0] slot,
                           input bit lift, input bit lower, input bit left,
                           input bit hp, input bit vp);
    item_t it;
    it.kind = kind;
    it.slot = slot;
    it.lift = lift;
    it.lower_switch = lower;
    it.left_switch = left;
    it.horiz_pulse = hp;
    it.vert_pulse = vp;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    slot_i <= slot;
    lift_i <= lift;
    lower_switch_i <= lower;
    left_switch_i <= left;
    horiz_pulse_i <= hp;
    vert_pulse_i <= vp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.predict_tick(it);
  endtask

  // Random tick shaped by where the sequencer stands, so that homing and
  // moves actually run to their ends, with some stray commands mixed in.
  task automatic send_random_tick();
    int         pick;
    logic [1:0] kind;
    logic [3:0] slot;
    bit         lift;
    bit         lower;
    bit         left;
    bit         hp;
    bit         vp;
    pick = $urandom_range(99);
    kind = KIND_TICK;
    slot = 4'($urandom_range(15));
    lift = 1'($urandom_range(1));
    lower = 1'($urandom_range(1));
    left = 1'($urandom_range(1));
    hp = 1'($urandom_range(1));
    vp = 1'($urandom_range(1));
    case (tracker.phase)
      PH_IDLE: begin
        if (pick < 35) begin
          kind = KIND_HOME;
          // At least half the homing runs start with both endstops released.
          if ($urandom_range(1) != 0) begin
            lower = 1'b0;
            left = 1'b0;
          end
        end else if (pick < 80) begin
          kind = KIND_MOVE;
        end else begin
          kind = 2'($urandom_range(3));
        end
      end
      PH_BACKOFF: begin
        // Mostly released, so that both the blocked and the seeking
        // outcome show up.
        if ($urandom_range(3) != 0) begin
          lower = 1'b0;
          left = 1'b0;
        end
      end
      PH_SEEK: begin
        lower = ($urandom_range(99) < 30);
        left = ($urandom_range(99) < 30);
      end
      default: begin
        hp = ($urandom_range(9) < 8);
        vp = ($urandom_range(9) < 8);
      end
    endcase
    // A command now and then while a sequence runs; the core must ignore it.
    if (tracker.phase != PH_IDLE && pick < 8) kind = 2'($urandom_range(3));
    send_tick(kind, slot, lift, lower, left, hp, vp);
  endtask

  // Drives the running sequence to its end so that registers can be changed.
  task automatic finish_sequence();
    while (tracker.phase != PH_IDLE) begin
      case (tracker.phase)
        PH_BACKOFF: send_tick(KIND_TICK, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        PH_SEEK:    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        default:    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
      endcase
    end
  endtask

  // Stops sending and waits until every predicted result has been returned,
  // so that the core has nothing left in flight.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    cfg_t c;
    tracker = new();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: short geometry and timings so that every sequence ends
    // within a few ticks.
    gap_pct = 6;
    stall_pct = 62;
    c = '0;
    c.column_origin = 14'd2;
    c.column_pitch = 14'd1;
    c.row_origin = 14'd1;
    c.row_pitch = 12'd1;
    c.lift_height = 12'd1;
    c.backoff_ticks = 16'd2;
    c.home_timeout_ticks = 16'd3;
    apply_config(c);

    // Endstops and encoder edges while idle change nothing.
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    // The unused kind acts as a plain tick.
    send_tick(KIND_UNUSED, 4'd15, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
    // Move to the base position while already there: done on its start tick.
    send_tick(KIND_MOVE, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    // Move to the second column with lift; edges on the start tick are ignored.
    send_tick(KIND_MOVE, 4'd2, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
    // Homing requested mid-move is ignored.
    send_tick(KIND_HOME, 4'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    // The vertical axis has stopped, so its edge does not count.
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    // Back to base: both axes run in the negative direction.
    send_tick(KIND_MOVE, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    // Homing from released endstops, both closing: success.
    send_tick(KIND_HOME, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    // Homing with the left endstop held through the backoff: blocked.
    send_tick(KIND_HOME, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    // Homing with the lower endstop released during backoff, then the
    // endstops never close and the seek times out.
    send_tick(KIND_HOME, 4'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(KIND_TICK, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    finish_sequence();
    wait_for_results();

    // Random part in six segments. Segments 0-1 stall the receiver often, 2-3
    // hold back the sender often, 4-5 run at full rate. Segment 1 uses all-zero
    // registers (zero backoff, zero timeout, every target at base); the
    // others use short random geometry so that moves finish quickly.
    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          gap_pct = 6;
          stall_pct = 62;
        end
        1: begin
          gap_pct = 62;
          stall_pct = 6;
        end
        default: begin
          gap_pct = 0;
          stall_pct = 0;
        end
      endcase
      c = '0;
      if (seg != 1) begin
        c.column_origin = 14'($urandom_range(20));
        c.column_pitch = 14'($urandom_range(12));
        c.row_origin = 14'($urandom_range(20));
        c.row_pitch = 12'($urandom_range(6));
        c.lift_height = 12'($urandom_range(8));
        c.backoff_ticks = 16'($urandom_range(6));
        c.home_timeout_ticks = 16'($urandom_range(30));
      end
      apply_config(c);
      for (int n = 0; n < SEG_TICKS; n++) begin
        // Once, the sender holds off until the core has returned everything.
        if (seg == 4 && n == SEG_TICKS / 2) wait_for_results();
        send_random_tick();
      end
      finish_sequence();
      wait_for_results();
    end

    // Largest register values. Homing starts from released endstops, since a
    // full-length backoff would take 65535 ticks. The move to slot 14 with
    // lift saturates the vertical target; only its first ticks are sent,
    // since the whole travel would take tens of thousands of ticks.
    gap_pct = 0;
    stall_pct = 0;
    c.column_origin = 14'h3FFF;
    c.column_pitch = 14'h3FFF;
    c.row_origin = 14'h3FFF;
    c.row_pitch = 12'hFFF;
    c.lift_height = 12'hFFF;
    c.backoff_ticks = 16'hFFFF;
    c.home_timeout_ticks = 16'hFFFF;
    apply_config(c);
    send_tick(KIND_HOME, 4'($urandom_range(15)), 1'b0, 1'b0, 1'b0,
              1'($urandom_range(1)), 1'($urandom_range(1)));
    repeat (5) begin
      send_tick(KIND_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)), 1'b0, 1'b0,
                1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    finish_sequence();
    send_tick(KIND_MOVE, 4'd14, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
    repeat (20) begin
      send_tick(KIND_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)),
                1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    wait_for_results();

    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
